/* hw/rtl/svh_pkg.sv */
package svh_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 16;

  // One table entry as a cell holds it
  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } entry_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic capture;   // latch compare flags against the new sample
    logic bump;      // sample already present: raise the matching count
    logic insert;    // sample is new and there is room: open a slot
    logic shift_out; // emit: every cell takes its right neighbour's entry
  } cell_ctrl_t;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_APPLY = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

endpackage

/* hw/rtl/svh_cell.sv */
module svh_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  svh_pkg::cell_ctrl_t                 ctrl,
  input  logic [svh_pkg::VALUE_W-1:0]         sample,
  input  svh_pkg::entry_t                     left,
  input  logic                                left_place,
  input  svh_pkg::entry_t                     right,
  output svh_pkg::entry_t                     own,
  output logic                                place,
  output logic                                hit
);
  import svh_pkg::*;

  logic               valid;
  logic [VALUE_W-1:0] value;
  logic [COUNT_W-1:0] count;

  assign own = '{valid: valid, value: value, count: count};

  // Compare against the request's sample; place marks "sample sorts at or before here"
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      hit   <= valid && (value == sample);
      place <= !valid || ($signed(value) > $signed(sample));
    end
  end

  // Entry valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift_out) begin
      valid <= right.valid;
    end else if (ctrl.insert && place) begin
      valid <= left_place ? left.valid : 1'b1;
    end
  end

  // Entry payload: shift, insert or count
  always_ff @(posedge clk) begin
    if (ctrl.shift_out) begin
      value <= right.value;
      count <= right.count;
    end else if (ctrl.insert && place) begin
      if (left_place) begin
        value <= left.value;
        count <= left.count;
      end else begin
        value <= sample;
        count <= COUNT_W'(1);
      end
    end else if (ctrl.bump && hit && !(&count)) begin
      count <= count + COUNT_W'(1);
    end
  end

endmodule

/* hw/rtl/sorted_value_histogram.sv */
// Channel   Handshake                Payload
// request   start / busy             sample_value, final_sample
// result    result_strobe (1 cycle)  distinct_value, occurrences, final_entry,
//                                    table_overflowed
//
// A sample is first compared in every cell of the sorted chain, then counted or
// inserted; busy is high while it is counted or inserted.
// A final sample then emits every entry, n of them (1..TABLE_ENTRIES), with
// results, registered from the head of the chain, on consecutive cycles.
// Reset (rst, synchronous) empties the chain and clears the overflow flag.
// Results cannot be held off; each is shown for one cycle only.
module sorted_value_histogram #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [svh_pkg::VALUE_W-1:0] sample_value,
  input  logic                        final_sample,
  output logic                        result_strobe,
  output logic [svh_pkg::VALUE_W-1:0] distinct_value,
  output logic [svh_pkg::COUNT_W-1:0] occurrences,
  output logic                        final_entry,
  output logic                        table_overflowed
);
  import svh_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [VALUE_W-1:0] sample;
  logic [VALUE_W-1:0] cell_sample;
  logic               last_sample;
  logic               overflow_seen;

  entry_t             cells  [TABLE_ENTRIES];
  logic               places [TABLE_ENTRIES];
  logic               hits   [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] hit_vec;
  logic               any_hit;
  logic               full;
  logic               accept;
  cell_ctrl_t         ctrl;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);
  assign full   = cells[TABLE_ENTRIES-1].valid;

  // Cells compare against the incoming sample, then insert the held one
  assign cell_sample = accept ? sample_value : sample;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_vec[i] = hits[i];
    end
  end
  assign any_hit = |hit_vec;

  // Broadcast control
  always_comb begin
    ctrl.capture   = accept;
    ctrl.bump      = (state == ST_APPLY) && any_hit;
    ctrl.insert    = (state == ST_APPLY) && !any_hit && !full;
    ctrl.shift_out = (state == ST_EMIT);
  end

  // The chain, smallest value in cell 0
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_p;

    if (g == 0) begin : g_first
      assign left_e = '0;
      assign left_p = 1'b0;
    end else begin : g_inner
      assign left_e = cells[g-1];
      assign left_p = places[g-1];
    end

    if (g == TABLE_ENTRIES - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_body
      assign right_e = cells[g+1];
    end

    svh_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .sample     (cell_sample),
      .left       (left_e),
      .left_place (left_p),
      .right      (right_e),
      .own        (cells[g]),
      .place      (places[g]),
      .hit        (hits[g])
    );
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      sample      <= sample_value;
      last_sample <= final_sample;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_APPLY;
      ST_APPLY: state_next = last_sample ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (!cells[1].valid) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Overflow flag, cleared once the run is out
  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_seen <= 1'b0;
    end else if (ctrl.shift_out && !cells[1].valid) begin
      overflow_seen <= 1'b0;
    end else if ((state == ST_APPLY) && !any_hit && full) begin
      overflow_seen <= 1'b1;
    end
  end

  // Result register, fed from the head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= ctrl.shift_out;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift_out) begin
      distinct_value   <= cells[0].value;
      occurrences      <= cells[0].count;
      final_entry      <= !cells[1].valid;
      table_overflowed <= overflow_seen;
    end
  end

endmodule

/* hw/rtl/svh_checker.sv */
module svh_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        result_strobe,
  input logic [svh_pkg::COUNT_W-1:0] occurrences,
  input logic                        final_entry,
  input logic                        table_overflowed
);
  import svh_pkg::*;

  // A run of results is unbroken until its final entry
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !final_entry |=> result_strobe)
    else $error("result run broken before final entry");

  // No result in the cycle after a request is taken
  a_no_result_after_request: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !result_strobe)
    else $error("result right after request");

  // Only the final entry may appear while the block is free
  a_busy_during_run: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !busy |-> final_entry)
    else $error("non-final result while idle");

  // Overflow flag is the same across one run
  a_overflow_steady: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !final_entry |=> $stable(table_overflowed))
    else $error("overflow flag changed within a run");

  // Every emitted entry was counted at least once
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> (occurrences != '0))
    else $error("zero occurrence count emitted");

endmodule

bind sorted_value_histogram svh_checker u_svh_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .result_strobe    (result_strobe),
  .occurrences      (occurrences),
  .final_entry      (final_entry),
  .table_overflowed (table_overflowed)
);

/* bench/sorted_value_histogram_tb.sv */
module sorted_value_histogram_tb;

  import svh_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned RANDOM_ITEMS = 80;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [COUNT_W-1:0] COUNT_CEILING = {COUNT_W{1'b1}};
  localparam logic [VALUE_W-1:0] MOST_NEGATIVE = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] MOST_POSITIVE = {1'b0, {(VALUE_W-1){1'b1}}};

  // One request as the sender presents it
  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               last;
  } sample_req_t;

  // One line of the sorted histogram as it should come out
  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic               last;
    logic               overflow;
  } hist_line_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [VALUE_W-1:0] sample_value = '0;
  logic               final_sample = 1'b0;
  logic               result_strobe;
  logic [VALUE_W-1:0] distinct_value;
  logic [COUNT_W-1:0] occurrences;
  logic               final_entry;
  logic               table_overflowed;

  sample_req_t sample_requests[$];
  hist_line_t  expected_lines[$];

  // Shadow of the block's table
  logic [VALUE_W-1:0] shadow_values[TABLE_DEPTH];
  logic [COUNT_W-1:0] shadow_counts[TABLE_DEPTH];
  int unsigned        shadow_used = 0;
  logic               shadow_overflow = 1'b0;

  int unsigned requests_taken = 0;
  int unsigned lines_checked = 0;
  int unsigned sets_closed = 0;
  int unsigned overflow_sets = 0;
  int unsigned saturated_lines = 0;
  int unsigned failures = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  sorted_value_histogram #(
    .TABLE_ENTRIES(TABLE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .sample_value(sample_value),
    .final_sample(final_sample),
    .result_strobe(result_strobe),
    .distinct_value(distinct_value),
    .occurrences(occurrences),
    .final_entry(final_entry),
    .table_overflowed(table_overflowed)
  );

  always #5 clk = ~clk;

  // Count one accepted sample; on the last of a set queue the sorted lines
  task automatic tally_sample(input sample_req_t req);
    logic [VALUE_W-1:0] vals[TABLE_DEPTH];
    logic [COUNT_W-1:0] cnts[TABLE_DEPTH];
    logic [VALUE_W-1:0] v;
    logic [COUNT_W-1:0] c;
    hist_line_t line;
    bit found;
    int j;
    found = 1'b0;
    for (int i = 0; i < shadow_used; i++) begin
      if (!found && shadow_values[i] == req.value) begin
        found = 1'b1;
        if (shadow_counts[i] != COUNT_CEILING) shadow_counts[i] = shadow_counts[i] + 1'b1;
      end
    end
    if (!found) begin
      if (shadow_used < TABLE_DEPTH) begin
        shadow_values[shadow_used] = req.value;
        shadow_counts[shadow_used] = COUNT_W'(1);
        shadow_used++;
      end else begin
        shadow_overflow = 1'b1;
      end
    end
    if (req.last) begin
      // insertion sort on signed value
      for (int i = 0; i < shadow_used; i++) begin
        v = shadow_values[i];
        c = shadow_counts[i];
        j = i;
        while (j > 0 && $signed(vals[j-1]) > $signed(v)) begin
          vals[j] = vals[j-1];
          cnts[j] = cnts[j-1];
          j--;
        end
        vals[j] = v;
        cnts[j] = c;
      end
      for (int i = 0; i < shadow_used; i++) begin
        line.value = vals[i];
        line.count = cnts[i];
        line.last = (i == shadow_used - 1);
        line.overflow = shadow_overflow;
        if (cnts[i] == COUNT_CEILING) saturated_lines++;
        expected_lines.push_back(line);
      end
      sets_closed++;
      if (shadow_overflow) overflow_sets++;
      shadow_used = 0;
      shadow_overflow = 1'b0;
    end
  endtask

  // Sender: bursts of requests with random gaps, holding while busy
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        tally_sample(sample_requests[0]);
        void'(sample_requests.pop_front());
        requests_taken++;
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (sample_requests.size() > 0) begin
        sample_value <= sample_requests[0].value;
        final_sample <= sample_requests[0].last;
        start <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Receiver: every strobe must match the oldest waiting line
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (expected_lines.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result: value %0d count %0d last %0b ovf %0b",
                   $signed(distinct_value), occurrences, final_entry, table_overflowed);
      end else begin
        if (distinct_value !== expected_lines[0].value ||
            occurrences !== expected_lines[0].count ||
            final_entry !== expected_lines[0].last ||
            table_overflowed !== expected_lines[0].overflow) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("mismatch: exp value %0d count %0d last %0b ovf %0b, got %0d %0d %0b %0b",
                     $signed(expected_lines[0].value), expected_lines[0].count,
                     expected_lines[0].last, expected_lines[0].overflow,
                     $signed(distinct_value), occurrences, final_entry, table_overflowed);
        end
        void'(expected_lines.pop_front());
        lines_checked++;
      end
    end
  end

  task automatic push_sample(input logic [VALUE_W-1:0] value, input logic last);
    sample_req_t req;
    req.value = value;
    req.last = last;
    sample_requests.push_back(req);
  endtask

  // Stimulus and end of run
  initial begin
    logic [VALUE_W-1:0] pool[4];
    logic [VALUE_W-1:0] v;
    int unsigned random_count;
    int unsigned set_len;

    // single sample set
    push_sample('0, 1'b1);
    // extremes, with repeats and the final one already present
    push_sample(MOST_NEGATIVE, 1'b0);
    push_sample(MOST_POSITIVE, 1'b0);
    push_sample('1, 1'b0);
    push_sample('0, 1'b0);
    push_sample(32'd1, 1'b0);
    push_sample(MOST_POSITIVE, 1'b0);
    push_sample(MOST_NEGATIVE, 1'b1);
    // final sample repeats a value
    push_sample(32'd5, 1'b0);
    push_sample(32'd5, 1'b0);
    push_sample(32'd5, 1'b1);

    // fill the table, then a dropped new value, a counted old one, a dropped final
    for (int i = 0; i < TABLE_DEPTH; i++)
      push_sample({i[5:0], 26'($urandom)}, 1'b0);
    push_sample({6'd7, 26'($urandom)} | 32'h1, 1'b0);
    push_sample(sample_requests[sample_requests.size() - 2].value, 1'b0);
    push_sample({6'd9, 26'($urandom)} | 32'h1, 1'b1);

    // random sets: mostly short with repeats, now and then over-full
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0 &&
          random_count + TABLE_DEPTH + 8 <= RANDOM_ITEMS) begin
        set_len = $urandom_range(TABLE_DEPTH + 1, TABLE_DEPTH + 8);
        for (int i = 0; i < set_len; i++) begin
          if ($urandom_range(0, 4) == 0 && i > 0)
            v = sample_requests[sample_requests.size() - 1].value;
          else
            v = {i[6:0], 25'($urandom)};
          push_sample(v, i == set_len - 1);
        end
      end else begin
        set_len = $urandom_range(1, 12);
        for (int k = 0; k < 4; k++) begin
          case ($urandom_range(0, 5))
            0: pool[k] = MOST_NEGATIVE;
            1: pool[k] = MOST_POSITIVE;
            2: pool[k] = 32'($signed($urandom_range(0, 6)) - 3);
            default: pool[k] = $urandom;
          endcase
        end
        for (int i = 0; i < set_len; i++) begin
          v = ($urandom_range(0, 5) == 0) ? $urandom : pool[$urandom_range(0, 3)];
          push_sample(v, i == set_len - 1);
        end
      end
      random_count += set_len;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (sample_requests.size() != 0 || start) @(posedge clk);
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 10) @(posedge clk);

    $display("%0d requests in %0d sets, %0d sorted lines checked", requests_taken,
             sets_closed, lines_checked);
    $display("%0d sets overflowed the table, %0d lines at the count ceiling",
             overflow_sets, saturated_lines);
    if (failures == 0) begin
      $display("sorted_value_histogram_tb OK");
    end else begin
      $display("%0d mismatches", failures);
      $display("sorted_value_histogram_tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6000000;
    $display("timeout");
    $display("sorted_value_histogram_tb NOT OK");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/svh_pkg.sv
hw/rtl/svh_cell.sv
hw/rtl/sorted_value_histogram.sv
hw/rtl/svh_checker.sv
bench/sorted_value_histogram_tb.sv
